// File: hdl/lrukv_pkg.sv
// ----------------------------------------------------------------------------
// lrukv_pkg: shared types and constants of the LRU key/value cache
// Sizes of the entry table, field widths, operation codes and the request and
// response records that pass between the cache modules.
// ----------------------------------------------------------------------------
package lrukv_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 14;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    localparam int RANK_BITS  = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);

    // operation codes carried in the kind field
    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef logic [ENTRIES-1:0] entry_vec_t;

    typedef struct packed {
        logic                         kind;
        logic [KEY_BITS-1:0]          key;
        logic signed [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic                         hit;
        logic signed [VALUE_BITS-1:0] read_value;
        logic                         evicted;
        logic [KEY_BITS-1:0]          evicted_key;
    } rsp_t;

endpackage

// File: hdl/lrukv_ifs.sv
// ----------------------------------------------------------------------------
// lrukv_ifs: channel interfaces of the LRU key/value cache
// Request, response and configuration channels, each a valid/ready pair with
// its payload and a source and a sink modport.
// ----------------------------------------------------------------------------
interface lrukv_req_if;
    import lrukv_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [KEY_BITS-1:0]          key;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output key, output value, input ready);
    modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

interface lrukv_rsp_if;
    import lrukv_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;
    logic [KEY_BITS-1:0]          evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lrukv_cfg_if;
    import lrukv_pkg::*;

    logic                valid;
    logic                ready;
    logic [CAP_BITS-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// File: hdl/lrukv_table.sv
// ----------------------------------------------------------------------------
// lrukv_table: entry table of the LRU key/value cache
// Holds keys, values, valid marks and recency ranks; looks up one request,
// forms its response and updates the table in the same cycle.
// ----------------------------------------------------------------------------
module lrukv_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  lrukv_pkg::req_t                  req,
    input  logic [lrukv_pkg::CAP_BITS-1:0]   capacity,
    output lrukv_pkg::rsp_t                  rsp
);
    import lrukv_pkg::*;

    logic [KEY_BITS-1:0]          key_reg   [ENTRIES];
    logic signed [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [RANK_BITS-1:0]         rank_reg  [ENTRIES];
    logic [RANK_BITS-1:0]         rank_next [ENTRIES];
    entry_vec_t                   valid_reg;
    entry_vec_t                   valid_next;
    logic [CNT_BITS-1:0]          occ_reg;
    logic [CNT_BITS-1:0]          occ_next;

    entry_vec_t                   match;
    entry_vec_t                   hit_oh;
    entry_vec_t                   free_oh;
    entry_vec_t                   victim_oh;
    entry_vec_t                   slot_oh;
    logic                         hit;
    logic                         is_put;
    logic                         full;
    logic                         evict;
    logic                         fill;
    logic                         touch;
    logic [CNT_BITS-1:0]          eff_cap;
    logic [CNT_BITS-1:0]          thr;
    logic [RANK_BITS-1:0]         lru_rank;
    logic [RANK_BITS-1:0]         hit_rank;
    logic [RANK_BITS-1:0]         victim_rank;
    logic signed [VALUE_BITS-1:0] hit_value;
    logic [KEY_BITS-1:0]          victim_key;

    // clamp capacity into 1 .. ENTRIES
    always_comb
    begin
        if (capacity == '0)
            eff_cap = CNT_BITS'(1);
        else if (int'(capacity) > ENTRIES)
            eff_cap = CNT_BITS'(ENTRIES);
        else
            eff_cap = CNT_BITS'(capacity);
    end

    // valid ranks form 0 .. occ-1, so the oldest entry holds rank occ-1
    assign lru_rank = RANK_BITS'(occ_reg - CNT_BITS'(1));

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]     = valid_reg[i] && (key_reg[i] == req.key);
            victim_oh[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
        end
    end

    assign hit_oh  = match & (~match + entry_vec_t'(1));
    assign free_oh = ~valid_reg & (valid_reg + entry_vec_t'(1));
    assign hit     = |match;
    assign is_put  = (req.kind == KIND_PUT);
    assign full    = (occ_reg >= eff_cap);
    assign evict   = is_put && !hit && full;
    assign fill    = is_put && !hit && !full;
    assign touch   = hit || evict || fill;

    // one-hot reads of the addressed entries
    always_comb
    begin
        hit_rank    = '0;
        hit_value   = '0;
        victim_rank = '0;
        victim_key  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_oh[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
            if (victim_oh[i])
            begin
                victim_rank = victim_rank | rank_reg[i];
                victim_key  = victim_key | key_reg[i];
            end
        end
    end

    always_comb
    begin
        if (hit)
        begin
            slot_oh = hit_oh;
            thr     = CNT_BITS'(hit_rank);
        end
        else if (evict)
        begin
            slot_oh = victim_oh;
            thr     = CNT_BITS'(victim_rank);
        end
        else
        begin
            slot_oh = fill ? free_oh : '0;
            thr     = CNT_BITS'(ENTRIES);
        end
    end

    // move the touched entry to the front, age everything newer than it
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (touch && slot_oh[i])
                rank_next[i] = '0;
            else if (touch && valid_reg[i] && (CNT_BITS'(rank_reg[i]) < thr))
                rank_next[i] = rank_reg[i] + RANK_BITS'(1);
        end
        if (fill)
        begin
            valid_next = valid_reg | free_oh;
            occ_next   = occ_reg + CNT_BITS'(1);
        end
    end

    always_comb
    begin
        rsp.hit         = hit;
        rsp.evicted     = evict;
        rsp.evicted_key = evict ? victim_key : '0;
        if (is_put)
            rsp.read_value = '0;
        else if (hit)
            rsp.read_value = hit_value;
        else
            rsp.read_value = '1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else if (step)
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    // key and value storage: no reset, read only while valid
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (step && is_put && slot_oh[i])
            begin
                value_reg[i] <= req.value;
                if (!hit)
                    key_reg[i] <= req.key;
            end
        end
    end

`ifndef SYNTH
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occ_reg) == $countones(valid_reg))
        else $error("occupancy count disagrees with valid marks");

    a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key present in more than one entry");

    a_fill_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && fill |=> occ_reg == $past(occ_reg) + CNT_BITS'(1))
        else $error("insert into free entry did not raise occupancy");

    a_victim_found: assert property (@(posedge clk) disable iff (!rst_n)
        evict |-> $onehot(victim_oh))
        else $error("no unique least recent entry on eviction");
`endif

endmodule

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, LRU replacement
// Top level: request input register, single-pass table lookup and update,
// response output register, capacity configuration register.
// ----------------------------------------------------------------------------
// The cache takes one get or put beat per clock while responses are taken
// and returns exactly one response beat per request, in order. A request is
// held in an input register, then in a single pass all 16 entries are
// compared against its key, the recency ranks are updated and the response
// is captured in an output register. The sustained rate is one request per
// cycle while responses are taken; the parallel compare and rank update over
// the entry table, done in a single pass, sets that figure. The input
// side keeps accepting while a response waits, up to one request held in the
// input register. Capacity (1 .. 16, 0 reads as 1, larger values as 16)
// should only be written while no request is outstanding; lowering it does
// not drop entries, each later insert then replaces the least recent entry.
// Reset empties the cache at once; no clearing pass is needed.
module lru_key_value_cache (
    input  logic clk,
    input  logic rst_n,
    lrukv_req_if.sink   req,
    lrukv_rsp_if.source rsp,
    lrukv_cfg_if.sink   cfg
);
    import lrukv_pkg::*;

    req_t                req_reg;
    req_t                req_in;
    logic                in_valid_reg;
    rsp_t                rsp_reg;
    rsp_t                rsp_calc;
    logic                out_valid_reg;
    logic [CAP_BITS-1:0] cap_reg;
    logic                out_free;
    logic                advance;

    // advance the held request when the output register is empty or draining
    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;
    assign cfg.ready = 1'b1;

    assign req_in.kind  = req.kind;
    assign req_in.key   = req.key;
    assign req_in.value = req.value;

    lrukv_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .req      (req_reg),
        .capacity (cap_reg),
        .rsp      (rsp_calc)
    );

    // control: valid flags and the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CAP_RESET;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
                cap_reg <= cfg.capacity;
        end
    end

    // payload: capture request beat, hold response until taken
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
            req_reg <= req_in;
        if (advance)
            rsp_reg <= rsp_calc;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = rsp_reg.hit;
    assign rsp.read_value  = rsp_reg.read_value;
    assign rsp.evicted     = rsp_reg.evicted;
    assign rsp.evicted_key = rsp_reg.evicted_key;

`ifndef SYNTH
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(req_reg))
        else $error("stalled request dropped or changed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(rsp_reg))
        else $error("waiting response overwritten");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no response");
`endif

endmodule
